// ===== hw/rtl/wnsc_pkg.sv =====
// ============================================================================
// wnsc_pkg - shared types and constants of the weighted nearest-seed classifier
// Holds the request codes, seed entry layout, fixed-point widths, the seed
// kind weight table and the controller/datapath command and status bundles.
// ============================================================================
package wnsc_pkg;

    localparam int ID_W      = 10;
    localparam int OUT_ID_W  = 11;
    localparam int COORD_W   = 16;
    localparam int RADIUS_W  = 16;
    localparam int KIND_W    = 2;
    localparam int FUNC_W    = 2;
    localparam int SCALE_W   = 16;
    localparam int CUTOFF_W  = 40;
    localparam int FACTOR_W  = 9;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int DIST_W    = SQ_W + 1;
    localparam int RR_W      = 2 * RADIUS_W;
    localparam int FS_W      = FACTOR_W + SCALE_W;
    localparam int WPROD_W   = RR_W + FS_W;
    localparam int WEIGHT_W  = WPROD_W - 16;
    localparam int SCORE_W   = WEIGHT_W + 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = CUTOFF_W;

    localparam logic [SCALE_W-1:0]  SCALE_FLOOR   = 16'd26;
    localparam logic [SCALE_W-1:0]  SCALE_RESET   = 16'd256;
    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET  = 40'd256;
    localparam logic signed [OUT_ID_W-1:0] ID_NONE = -11'sd1;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_SCALE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECONDARY_CUTOFF = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_QUERY = 2'd1,
        FUNC_CLEAR = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]            id;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic [RADIUS_W-1:0]        radius;
        logic [KIND_W-1:0]          kind;
    } t_seed;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // a request is accepted this cycle
        logic issue;     // read the next seed into the scoring pipeline
        logic publish;   // load the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;      // no seeds stored
        logic scan_last;  // the seed being issued is the last stored one
        logic pipe_busy;  // a seed is still in the scoring pipeline
        logic out_free;   // output register can take a new result
    } t_stat;

    // Kind weight factors 1.0, 0.95, 0.90, 0.75 in Q1.8, rounded down.
    function automatic logic [FACTOR_W-1:0] kind_factor(input logic [KIND_W-1:0] kind);
        logic [FACTOR_W-1:0] f;
        case (kind)
            2'd0:    f = 9'd256;
            2'd1:    f = 9'd243;
            2'd2:    f = 9'd230;
            default: f = 9'd192;
        endcase
        return f;
    endfunction

endpackage

// ===== hw/rtl/wnsc_ctrl.sv =====
// ============================================================================
// wnsc_ctrl - request sequencer
// Accepts one request at a time, steps the seed scan for queries and hands
// the finished result to the output register.
// ============================================================================
module wnsc_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [wnsc_pkg::FUNC_W-1:0]   i_func,
    input  wnsc_pkg::t_stat               i_stat,
    output wnsc_pkg::t_cmd                o_cmd
);

    wnsc_pkg::t_state r_state;
    wnsc_pkg::t_state n_state;
    logic             w_accept;
    logic             w_is_query;

    // Nothing is taken while reset is held.
    assign w_accept   = i_valid && i_rst_n && (r_state == wnsc_pkg::ST_IDLE);
    assign w_is_query = (wnsc_pkg::t_func'(i_func) == wnsc_pkg::FUNC_QUERY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wnsc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wnsc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    // A query over an empty table has nothing to scan.
                    if (w_is_query && !i_stat.empty) begin
                        n_state = wnsc_pkg::ST_SCAN;
                    end else begin
                        n_state = wnsc_pkg::ST_FIN;
                    end
                end
            end
            wnsc_pkg::ST_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = wnsc_pkg::ST_DRAIN;
                end
            end
            wnsc_pkg::ST_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = wnsc_pkg::ST_FIN;
                end
            end
            wnsc_pkg::ST_FIN: begin
                if (i_stat.out_free) begin
                    n_state = wnsc_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_ready       = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.issue   = 1'b0;
        o_cmd.publish = 1'b0;
        unique case (r_state)
            wnsc_pkg::ST_IDLE: begin
                o_ready       = i_rst_n;
                o_cmd.capture = w_accept;
            end
            wnsc_pkg::ST_SCAN: begin
                o_cmd.issue = 1'b1;
            end
            wnsc_pkg::ST_DRAIN: begin
            end
            wnsc_pkg::ST_FIN: begin
                o_cmd.publish = i_stat.out_free;
            end
        endcase
    end

endmodule

// ===== hw/rtl/wnsc_dp.sv =====
// ============================================================================
// wnsc_dp - seed table, scoring pipeline and result tracking
// Stores seeds in a single-port-write memory, scores one seed per cycle in a
// four-stage pipeline and keeps the best and runner-up seeds.
// ============================================================================
module wnsc_dp #(
    parameter int MAX_SEEDS = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  wnsc_pkg::t_cmd                         i_cmd,
    output wnsc_pkg::t_stat                        o_stat,
    input  logic [wnsc_pkg::FUNC_W-1:0]            i_func,
    input  logic [wnsc_pkg::ID_W-1:0]              i_seed_id,
    input  logic signed [wnsc_pkg::COORD_W-1:0]    i_seed_x,
    input  logic signed [wnsc_pkg::COORD_W-1:0]    i_seed_y,
    input  logic [wnsc_pkg::RADIUS_W-1:0]          i_seed_radius,
    input  logic [wnsc_pkg::KIND_W-1:0]            i_seed_kind,
    input  logic signed [wnsc_pkg::COORD_W-1:0]    i_query_x,
    input  logic signed [wnsc_pkg::COORD_W-1:0]    i_query_y,
    input  logic                                   i_cfg_valid,
    input  logic [wnsc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [wnsc_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic                                   o_accepted,
    output logic signed [wnsc_pkg::OUT_ID_W-1:0]   o_best_id,
    output logic signed [wnsc_pkg::OUT_ID_W-1:0]   o_runner_up_id
);

    localparam int CNT_W = $clog2(MAX_SEEDS + 1);
    localparam int IDX_W = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_SEEDS);

    localparam int SW = wnsc_pkg::SCORE_W;

    // Configuration registers.
    logic [wnsc_pkg::SCALE_W-1:0]  r_weight_scale;
    logic [wnsc_pkg::CUTOFF_W-1:0] r_cutoff;

    // Table.
    wnsc_pkg::t_seed r_mem [MAX_SEEDS];
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_scan_idx;
    logic             w_full;
    logic             w_load;
    wnsc_pkg::t_func  w_func;

    // Per-request operands.
    logic signed [wnsc_pkg::COORD_W-1:0] r_qx;
    logic signed [wnsc_pkg::COORD_W-1:0] r_qy;
    logic [wnsc_pkg::SCALE_W-1:0]        r_scale;
    logic                                r_acc;

    // Pipeline stage 1: table read.
    logic            r_v1;
    wnsc_pkg::t_seed r_rd;
    // Stage 2: differences and first products.
    logic                                r_v2;
    logic [wnsc_pkg::ID_W-1:0]           r_id2;
    logic signed [wnsc_pkg::DIFF_W-1:0]  r_dx;
    logic signed [wnsc_pkg::DIFF_W-1:0]  r_dy;
    logic [wnsc_pkg::RR_W-1:0]           r_rr;
    logic [wnsc_pkg::FS_W-1:0]           r_fs;
    // Stage 3: squares and weight.
    logic                                r_v3;
    logic [wnsc_pkg::ID_W-1:0]           r_id3;
    logic [wnsc_pkg::SQ_W-1:0]           r_dx2;
    logic [wnsc_pkg::SQ_W-1:0]           r_dy2;
    logic [wnsc_pkg::WEIGHT_W-1:0]       r_w;
    // Stage 4: score.
    logic                                r_v4;
    logic [wnsc_pkg::ID_W-1:0]           r_id4;
    logic signed [SW-1:0]                r_score;

    logic signed [2*wnsc_pkg::DIFF_W-1:0] w_dx2_full;
    logic signed [2*wnsc_pkg::DIFF_W-1:0] w_dy2_full;
    logic [wnsc_pkg::WPROD_W-1:0]         w_wprod;
    logic [wnsc_pkg::DIST_W-1:0]          w_dist2;

    // Tracker.
    logic                       r_have_best;
    logic                       r_have_second;
    logic signed [SW-1:0]       r_best;
    logic signed [SW-1:0]       r_second;
    logic [wnsc_pkg::ID_W-1:0]  r_best_id;
    logic [wnsc_pkg::ID_W-1:0]  r_second_id;
    logic                       n_have_best;
    logic                       n_have_second;
    logic signed [SW-1:0]       n_best;
    logic signed [SW-1:0]       n_second;
    logic [wnsc_pkg::ID_W-1:0]  n_best_id;
    logic [wnsc_pkg::ID_W-1:0]  n_second_id;

    logic [SW-1:0]              w_margin;
    logic                       w_within;

    // Output register.
    logic                                 r_out_valid;
    logic                                 r_out_acc;
    logic signed [wnsc_pkg::OUT_ID_W-1:0] r_out_best;
    logic signed [wnsc_pkg::OUT_ID_W-1:0] r_out_runner;

    assign w_func = wnsc_pkg::t_func'(i_func);
    assign w_full = (r_count == FULL_COUNT);
    assign w_load = i_cmd.capture && (w_func == wnsc_pkg::FUNC_LOAD) && !w_full;

    assign o_stat.empty     = (r_count == '0);
    assign o_stat.scan_last = ((CNT_W'(r_scan_idx) + CNT_W'(1)) == r_count);
    assign o_stat.pipe_busy = r_v1 || r_v2 || r_v3 || r_v4;
    assign o_stat.out_free  = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_scale <= wnsc_pkg::SCALE_RESET;
            r_cutoff       <= wnsc_pkg::CUTOFF_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wnsc_pkg::CFG_WEIGHT_SCALE: begin
                    r_weight_scale <= i_cfg_data[wnsc_pkg::SCALE_W-1:0];
                end
                wnsc_pkg::CFG_SECONDARY_CUTOFF: begin
                    r_cutoff <= i_cfg_data;
                end
            endcase
        end
    end

    // Seed memory: one write port at the fill count, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mem[r_count[IDX_W-1:0]] <= '{id: i_seed_id, x: i_seed_x, y: i_seed_y,
                                           radius: i_seed_radius, kind: i_seed_kind};
        end
        r_rd <= r_mem[r_scan_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_scan_idx <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_v4       <= 1'b0;
        end else begin
            if (w_load) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.capture && (w_func == wnsc_pkg::FUNC_CLEAR)) begin
                r_count <= '0;
            end
            if (i_cmd.capture) begin
                r_scan_idx <= '0;
            end else if (i_cmd.issue) begin
                r_scan_idx <= r_scan_idx + IDX_W'(1);
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_qx    <= i_query_x;
            r_qy    <= i_query_y;
            r_scale <= (r_weight_scale < wnsc_pkg::SCALE_FLOOR) ?
                       wnsc_pkg::SCALE_FLOOR : r_weight_scale;
            r_acc   <= w_load || (w_func == wnsc_pkg::FUNC_QUERY)
                              || (w_func == wnsc_pkg::FUNC_CLEAR);
        end
    end

    assign w_dx2_full = r_dx * r_dx;
    assign w_dy2_full = r_dy * r_dy;
    assign w_wprod    = wnsc_pkg::WPROD_W'(r_rr) * wnsc_pkg::WPROD_W'(r_fs);
    assign w_dist2    = wnsc_pkg::DIST_W'(r_dx2) + wnsc_pkg::DIST_W'(r_dy2);

    always_ff @(posedge i_clk) begin
        r_id2 <= r_rd.id;
        r_dx  <= wnsc_pkg::DIFF_W'(r_qx) - wnsc_pkg::DIFF_W'(r_rd.x);
        r_dy  <= wnsc_pkg::DIFF_W'(r_qy) - wnsc_pkg::DIFF_W'(r_rd.y);
        r_rr  <= wnsc_pkg::RR_W'(r_rd.radius) * wnsc_pkg::RR_W'(r_rd.radius);
        r_fs  <= wnsc_pkg::FS_W'(wnsc_pkg::kind_factor(r_rd.kind))
                 * wnsc_pkg::FS_W'(r_scale);

        r_id3 <= r_id2;
        r_dx2 <= w_dx2_full[wnsc_pkg::SQ_W-1:0];
        r_dy2 <= w_dy2_full[wnsc_pkg::SQ_W-1:0];
        r_w   <= w_wprod[wnsc_pkg::WPROD_W-1:16];

        r_id4   <= r_id3;
        r_score <= SW'(w_dist2) - SW'(r_w);
    end

    always_comb begin
        n_have_best   = r_have_best;
        n_have_second = r_have_second;
        n_best        = r_best;
        n_second      = r_second;
        n_best_id     = r_best_id;
        n_second_id   = r_second_id;
        if (i_cmd.capture) begin
            n_have_best   = 1'b0;
            n_have_second = 1'b0;
        end else if (r_v4) begin
            if (!r_have_best || (r_score < r_best)) begin
                if (r_have_best) begin
                    n_have_second = 1'b1;
                    n_second      = r_best;
                    n_second_id   = r_best_id;
                end
                n_have_best = 1'b1;
                n_best      = r_score;
                n_best_id   = r_id4;
            end else if (!r_have_second || (r_score < r_second)) begin
                n_have_second = 1'b1;
                n_second      = r_score;
                n_second_id   = r_id4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_best   <= 1'b0;
            r_have_second <= 1'b0;
        end else begin
            r_have_best   <= n_have_best;
            r_have_second <= n_have_second;
        end
        r_best      <= n_best;
        r_second    <= n_second;
        r_best_id   <= n_best_id;
        r_second_id <= n_second_id;
    end

    // The runner-up never scores below the best, so the margin is non-negative.
    assign w_margin = SW'(r_second - r_best);
    assign w_within = (w_margin <= SW'(r_cutoff));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_acc    <= r_acc;
            r_out_best   <= r_have_best ?
                            $signed({1'b0, r_best_id}) : wnsc_pkg::ID_NONE;
            r_out_runner <= (r_have_second && w_within) ?
                            $signed({1'b0, r_second_id}) : wnsc_pkg::ID_NONE;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_accepted     = r_out_acc;
    assign o_best_id      = r_out_best;
    assign o_runner_up_id = r_out_runner;

endmodule

// ===== hw/rtl/weighted_nearest_seed_classifier.sv =====
// ============================================================================
// weighted_nearest_seed_classifier - power-diagram nearest seed lookup
// Loads, clears and queries a table of weighted seeds and reports the
// lowest-scoring seed and a runner-up within a score margin.
// ============================================================================
// Usage notes.
// The request channel (i_valid/o_ready) carries one request per handshake:
// load a seed, query a point, or clear the table, selected by i_func. Every
// request produces exactly one response on the response channel
// (o_valid/i_ready), in request order.
// The configuration channel (i_cfg_valid/o_cfg_ready) is ready whenever reset
// is released and writes the weight scale (index 0) or the runner-up cutoff
// (index 1). It should only be used while no request is in flight.
// A load, clear or undefined request goes straight to the finish state once it
// is accepted. A query first scans the stored seeds: one seed enters the
// four-stage scoring pipeline per cycle from the single read port of the seed
// memory, and the pipeline then drains.
// Throughput is one request at a time; the next request is accepted as soon
// as the previous response is loaded into the output register.
// A stalled receiver holds the response in the output register; the block
// may accept and finish one more request meanwhile, then waits until the
// held response is taken.
// Reset empties the seed table at once (fill count to zero), drops any
// pending response, holds both ready outputs low and returns the weight
// scale to 1.0 and the cutoff to 256.
// ============================================================================
module weighted_nearest_seed_classifier #(
    parameter int MAX_SEEDS = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [wnsc_pkg::FUNC_W-1:0]            i_func,
    input  logic [wnsc_pkg::ID_W-1:0]              i_seed_id,
    input  logic signed [wnsc_pkg::COORD_W-1:0]    i_seed_x,
    input  logic signed [wnsc_pkg::COORD_W-1:0]    i_seed_y,
    input  logic [wnsc_pkg::RADIUS_W-1:0]          i_seed_radius,
    input  logic [wnsc_pkg::KIND_W-1:0]            i_seed_kind,
    input  logic signed [wnsc_pkg::COORD_W-1:0]    i_query_x,
    input  logic signed [wnsc_pkg::COORD_W-1:0]    i_query_y,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [wnsc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [wnsc_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic                                   o_accepted,
    output logic signed [wnsc_pkg::OUT_ID_W-1:0]   o_best_id,
    output logic signed [wnsc_pkg::OUT_ID_W-1:0]   o_runner_up_id
);

    wnsc_pkg::t_cmd  w_cmd;
    wnsc_pkg::t_stat w_stat;

    // Configuration writes are taken in any cycle outside reset.
    assign o_cfg_ready = i_rst_n;

    // The controller sequences each request; the datapath owns all storage.
    wnsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_func  (i_func),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    wnsc_dp #(
        .MAX_SEEDS (MAX_SEEDS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_func         (i_func),
        .i_seed_id      (i_seed_id),
        .i_seed_x       (i_seed_x),
        .i_seed_y       (i_seed_y),
        .i_seed_radius  (i_seed_radius),
        .i_seed_kind    (i_seed_kind),
        .i_query_x      (i_query_x),
        .i_query_y      (i_query_y),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_accepted     (o_accepted),
        .o_best_id      (o_best_id),
        .o_runner_up_id (o_runner_up_id)
    );

endmodule

// ===== hw/rtl/wnsc_chk.sv =====
// ============================================================================
// wnsc_chk - port-level checks for the weighted nearest-seed classifier
// Watches the request and response channels and flags illegal behavior.
// ============================================================================
module wnsc_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_ready,
    input logic                                 o_valid,
    input logic                                 i_ready,
    input logic                                 o_accepted,
    input logic signed [wnsc_pkg::OUT_ID_W-1:0] o_best_id,
    input logic signed [wnsc_pkg::OUT_ID_W-1:0] o_runner_up_id
);

    // A held response must not disappear before it is taken.
    a_resp_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("response dropped while stalled");

    // Only one request is worked on at a time.
    a_one_at_a_time : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken while another is in flight");

    // Refused requests never name a seed.
    a_refused_no_ids : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_accepted |->
            (o_best_id == wnsc_pkg::ID_NONE) && (o_runner_up_id == wnsc_pkg::ID_NONE))
        else $error("refused request reports a seed");

    // A runner-up implies a best seed.
    a_runner_needs_best : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_runner_up_id != wnsc_pkg::ID_NONE) |->
            (o_best_id != wnsc_pkg::ID_NONE))
        else $error("runner-up reported without a best seed");

endmodule

bind weighted_nearest_seed_classifier wnsc_chk u_wnsc_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_accepted     (o_accepted),
    .o_best_id      (o_best_id),
    .o_runner_up_id (o_runner_up_id)
);
